// ===== rtl/core/bitmap_slab_allocator_macros.svh =====
// Assertion macros for the bitmap slab allocator.
// Needs nothing else; included by the top level only.
`ifndef BITMAP_SLAB_ALLOCATOR_MACROS_SVH
`define BITMAP_SLAB_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bsa: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsa: next-cycle check failed");

`endif

// ===== rtl/core/bsa_pkg.sv =====
// Package for the bitmap slab allocator: word types, codes, widths and the
// lowest-clear-slot search. No dependencies.
package bsa_pkg;

	localparam int DEF_NUM_SHARDS = 64;
	localparam int SLOTS          = 16;
	localparam int SLOT_W         = 4;
	localparam int IDX_W          = 10;
	localparam int SHARD_W        = IDX_W - SLOT_W;
	localparam logic [SLOTS-1:0] FULL_MAP = '1;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_BAD_FREE  = 2'd2
	} status_t;

	typedef struct packed {
		func_t            func;
		logic [IDX_W-1:0] elem_index;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] alloc_index;
	} rsp_t;

	// {found, slot}: lowest clear bit of the map
	function automatic logic [SLOT_W:0] lowest_clear(input logic [SLOTS-1:0] map);
		logic [SLOT_W:0] res;
		res = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!map[i]) res = {1'b1, SLOT_W'(i)};
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/bsa_store.sv =====
// Shard store: used-map and link memories with a fill mark that stands in
// for the reset contents of never-written shards. Depends on bsa_pkg.
module bsa_store import bsa_pkg::*; #(
	parameter int NUM_SHARDS = DEF_NUM_SHARDS,
	localparam int AW = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1,
	localparam int LW = $clog2(NUM_SHARDS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [SLOTS-1:0] rd_map,
	output logic [LW-1:0]    rd_link,
	input  logic             map_we,
	input  logic             link_we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [SLOTS-1:0] wr_map,
	input  logic [LW-1:0]    wr_link
);

	logic [SLOTS-1:0] map_mem  [NUM_SHARDS];
	logic [LW-1:0]    link_mem [NUM_SHARDS];

	logic [SLOTS-1:0] map_rd_s1;
	logic [LW-1:0]    link_rd_s1;
	logic [AW-1:0]    addr_s1;
	logic             hit_s1;
	logic [LW-1:0]    fill_q;

	always_ff @(posedge clk) begin
		if (map_we) map_mem[wr_addr] <= wr_map;
		// seed the link of a shard on its first write
		if (link_we) begin
			link_mem[wr_addr] <= wr_link;
		end else if (map_we && (LW'(wr_addr) >= fill_q)) begin
			link_mem[wr_addr] <= LW'(wr_addr) + LW'(1);
		end
		if (rd_en) begin
			map_rd_s1  <= map_mem[rd_addr];
			link_rd_s1 <= link_mem[rd_addr];
			addr_s1    <= rd_addr;
			hit_s1     <= (LW'(rd_addr) < fill_q);
		end
	end

	// shards at or above the fill mark have never been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (map_we && (LW'(wr_addr) >= fill_q)) begin
			fill_q <= LW'(wr_addr) + LW'(1);
		end
	end

	assign rd_map  = hit_s1 ? map_rd_s1 : '0;
	assign rd_link = hit_s1 ? link_rd_s1 : LW'(addr_s1) + LW'(1);

endmodule

// ===== rtl/core/bitmap_slab_allocator.sv =====
// Bitmap slab allocator top level: request decode, read-modify-write of the
// shard store and the free-list head. Depends on bsa_pkg, bsa_store, macros.
//
//   channel   handshake            word
//   request   start / busy         req_t {func, elem_index}
//   result    done (strobe)        rsp_t {status, alloc_index}
//
// The store is read at the accepting edge and written back at the next edge,
// while busy holds off the next request until the last one is written back.
// The result strobe rises after the write-back edge, where it and the result
// word are registered.
// After reset the block accepts at once; untouched shards read as reset.
// The result is shown for one cycle and cannot be held off.
`include "bitmap_slab_allocator_macros.svh"

module bitmap_slab_allocator import bsa_pkg::*; #(
	parameter int NUM_SHARDS = DEF_NUM_SHARDS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	localparam int AW = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;
	localparam int LW = $clog2(NUM_SHARDS + 1);
	localparam int CW = (LW > SHARD_W) ? LW : SHARD_W;

	logic             accept;
	logic [AW-1:0]    rd_addr;
	logic [SLOTS-1:0] rd_map;
	logic [LW-1:0]    rd_link;

	logic             valid_s1;
	func_t            func_s1;
	logic [IDX_W-1:0] elem_s1;

	logic [LW-1:0]    head_q;
	logic             done_q;
	rsp_t             result_q;

	logic [CW-1:0]     shard_c;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W:0]   lc;
	logic [SLOTS-1:0]  set_map;
	logic              map_we;
	logic              link_we;
	logic [AW-1:0]     wr_addr;
	logic [SLOTS-1:0]  wr_map;
	logic [LW-1:0]     head_d;
	rsp_t              rsp_d;

	assign accept  = start && !busy;
	assign rd_addr = (request.func == FN_ALLOC) ? AW'(head_q)
		: AW'(CW'(request.elem_index[IDX_W-1:SLOT_W]));

	bsa_store #(.NUM_SHARDS(NUM_SHARDS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_map  (rd_map),
		.rd_link (rd_link),
		.map_we  (map_we),
		.link_we (link_we),
		.wr_addr (wr_addr),
		.wr_map  (wr_map),
		.wr_link (head_q)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= request.func;
			elem_s1 <= request.elem_index;
		end
		if (valid_s1) result_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			head_q   <= '0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
			head_q   <= head_d;
		end
	end

	always_comb begin
		shard_c   = CW'(elem_s1[IDX_W-1:SLOT_W]);
		free_slot = elem_s1[SLOT_W-1:0];
		lc        = lowest_clear(rd_map);
		set_map   = rd_map | (SLOTS'(1) << lc[SLOT_W-1:0]);
		map_we    = 1'b0;
		link_we   = 1'b0;
		wr_addr   = AW'(head_q);
		wr_map    = set_map;
		head_d    = head_q;
		rsp_d     = '{status: ST_OK, alloc_index: '0};
		if (valid_s1) begin
			unique case (func_s1)
				FN_ALLOC: begin
					priority if (head_q >= LW'(NUM_SHARDS) || !lc[SLOT_W]) begin
						rsp_d.status = ST_EXHAUSTED;
					end else begin
						map_we            = 1'b1;
						rsp_d.alloc_index = IDX_W'({head_q, lc[SLOT_W-1:0]});
						if (set_map == FULL_MAP) head_d = rd_link;
					end
				end
				FN_FREE: begin
					wr_addr = AW'(shard_c);
					wr_map  = rd_map & ~(SLOTS'(1) << free_slot);
					priority if (shard_c >= CW'(NUM_SHARDS) || !rd_map[free_slot]) begin
						rsp_d.status = ST_BAD_FREE;
					end else begin
						map_we = 1'b1;
						if (rd_map == FULL_MAP) begin
							link_we = 1'b1;
							head_d  = LW'(shard_c);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign busy   = valid_s1;
	assign done   = done_q;
	assign result = result_q;

	`BSA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`BSA_ASSERT_NEXT(a_busy_done, clk, arst_n, busy, done && !busy)
	`BSA_ASSERT_NOW(a_err_zero, clk, arst_n, done && result.status != ST_OK,
		result.alloc_index == '0)
	`BSA_ASSERT_NOW(a_head_range, clk, arst_n, 1'b1, head_q <= LW'(NUM_SHARDS))
endmodule

// ===== tb/bitmap_slab_allocator_tb.sv =====
// Self-checking testbench for the bitmap slab allocator: directed table, pool fill to
// exhaustion and churn with relinking, each result checked against the table or its pool model.
// Depends on bsa_pkg and the bitmap_slab_allocator top level.
module bitmap_slab_allocator_tb import bsa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SHARDS  = DEF_NUM_SHARDS;
	localparam int IDLE_LIMIT  = 2000;
	localparam int FILL_ENOUGH = 8;
	localparam int CHURN_WORDS = 250;

	typedef struct {
		req_t word;
		int   reps;
		bit   typed;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	logic [SLOTS-1:0] used_map [NUM_SHARDS];
	int unsigned shard_link [NUM_SHARDS];
	int unsigned list_head;

	rsp_t pending_outcomes [$];
	logic [IDX_W-1:0] held_elems [$];
	int mismatches = 0;
	int exhausted_seen = 0;
	int burst_left;
	int idle_cycles = 0;

	bitmap_slab_allocator #(.NUM_SHARDS(NUM_SHARDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void reset_pool_model();
		for (int i = 0; i < NUM_SHARDS; i++) begin
			used_map[i] = '0;
			shard_link[i] = i + 1;
		end
		list_head = 0;
	endfunction

	function automatic rsp_t allocator_outcome(input req_t word);
		rsp_t r;
		logic [SLOTS-1:0] map;
		int unsigned shard;
		int unsigned slot;
		bit found;
		r.status = ST_OK;
		r.alloc_index = '0;
		if (word.func == FN_ALLOC) begin
			if (list_head >= NUM_SHARDS) begin
				r.status = ST_EXHAUSTED;
			end else begin
				map = used_map[list_head];
				found = 1'b0;
				slot = 0;
				for (int s = 0; s < SLOTS; s++) begin
					if (!found && !map[s]) begin
						found = 1'b1;
						slot = s;
					end
				end
				if (!found) begin
					r.status = ST_EXHAUSTED;
				end else begin
					map[slot] = 1'b1;
					used_map[list_head] = map;
					r.alloc_index = IDX_W'(list_head * SLOTS + slot);
					if (map == FULL_MAP)
						list_head = shard_link[list_head];
				end
			end
		end else begin
			shard = word.elem_index / SLOTS;
			slot = word.elem_index % SLOTS;
			if (shard >= NUM_SHARDS) begin
				r.status = ST_BAD_FREE;
			end else if (!used_map[shard][slot]) begin
				r.status = ST_BAD_FREE;
			end else begin
				if (used_map[shard] == FULL_MAP) begin
					shard_link[shard] = list_head;
					list_head = shard;
				end
				used_map[shard][slot] = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic issue(input req_t word, input bit typed, input rsp_t want);
		rsp_t got;
		int hits [$];
		int gap;
		@(negedge clk);
		start <= 1'b1;
		request <= word;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		got = allocator_outcome(word);
		pending_outcomes.push_back(typed ? want : got);
		if (got.status == ST_EXHAUSTED)
			exhausted_seen++;
		if (got.status == ST_OK) begin
			if (word.func == FN_ALLOC) begin
				held_elems.push_back(got.alloc_index);
			end else begin
				hits = held_elems.find_first_index(x) with (x == word.elem_index);
				if (hits.size() != 0)
					held_elems.delete(hits[0]);
			end
		end
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			request <= req_t'($urandom);
			repeat (gap - 1)
				@(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	function automatic req_t alloc_word();
		req_t w;
		w.func = FN_ALLOC;
		w.elem_index = IDX_W'($urandom);
		return w;
	endfunction

	function automatic req_t free_word(input int pct_held);
		req_t w;
		w.func = FN_FREE;
		if (held_elems.size() != 0 && $urandom_range(0, 99) < pct_held)
			w.elem_index = held_elems[$urandom_range(0, held_elems.size() - 1)];
		else
			w.elem_index = IDX_W'($urandom);
		return w;
	endfunction

	always @(posedge clk) begin
		rsp_t w;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected word status=%0d alloc_index=%0d", $time,
					result.status, result.alloc_index);
				mismatches++;
			end else begin
				w = pending_outcomes.pop_front();
				if (result.status !== w.status) begin
					$display("%0t: status expected %0d actual %0d", $time, w.status,
						result.status);
					mismatches++;
				end
				if (result.alloc_index !== w.alloc_index) begin
					$display("%0t: alloc_index expected %0d actual %0d", $time,
						w.alloc_index, result.alloc_index);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("bitmap_slab_allocator_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		plan_row_t plan [13];
		int r;
		plan = '{
			'{'{FN_ALLOC, 10'd0},    1, 1'b1, '{ST_OK, 10'd0}},
			'{'{FN_ALLOC, 10'd0},    1, 1'b1, '{ST_OK, 10'd1}},
			'{'{FN_FREE,  10'd0},    1, 1'b1, '{ST_OK, 10'd0}},
			'{'{FN_FREE,  10'd0},    1, 1'b1, '{ST_BAD_FREE, 10'd0}},
			'{'{FN_FREE,  10'h3FF},  1, 1'b1, '{ST_BAD_FREE, 10'd0}},
			'{'{FN_ALLOC, 10'h3FF},  1, 1'b1, '{ST_OK, 10'd0}},
			'{'{FN_ALLOC, 10'h155}, 14, 1'b0, '{ST_OK, 10'd0}},
			'{'{FN_ALLOC, 10'h2AA},  1, 1'b1, '{ST_OK, 10'd16}},
			'{'{FN_FREE,  10'd1},    1, 1'b0, '{ST_OK, 10'd0}},
			'{'{FN_ALLOC, 10'd0},    1, 1'b1, '{ST_OK, 10'd1}},
			'{'{FN_ALLOC, 10'd0},    1, 1'b1, '{ST_OK, 10'd17}},
			'{'{FN_FREE,  10'd17},   1, 1'b0, '{ST_OK, 10'd0}},
			'{'{FN_FREE,  10'd17},   1, 1'b1, '{ST_BAD_FREE, 10'd0}}
		};
		reset_pool_model();
		burst_left = $urandom_range(1, 40);
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			repeat (plan[i].reps)
				issue(plan[i].word, plan[i].typed, plan[i].want);

		// fill the pool until allocation keeps failing, with sparse frees
		while (exhausted_seen < FILL_ENOUGH) begin
			r = $urandom_range(0, 99);
			if (r < 92)
				issue(alloc_word(), 1'b0, '0);
			else
				issue(free_word(r < 97 ? 100 : 0), 1'b0, '0);
		end

		// hold until every word has come back
		@(negedge clk);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);

		repeat (CHURN_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				issue(alloc_word(), 1'b0, '0);
			else
				issue(free_word(r < 90 ? 100 : 0), 1'b0, '0);
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (6)
			@(posedge clk);
		if (mismatches == 0)
			$display("bitmap_slab_allocator_tb OK");
		else
			$display("bitmap_slab_allocator_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bsa_pkg.sv
rtl/core/bsa_store.sv
rtl/core/bitmap_slab_allocator.sv
tb/bitmap_slab_allocator_tb.sv
